[hw/rtl/assert_macros.svh]
// Assertion macros for the checker file cbc_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed one cycle later");

`endif

[hw/rtl/cbc_pkg.sv]
package cbc_pkg;

	// Bank limits of the controller and the size of one RAM bank.
	localparam int MAX_ROM_BANKS  = 512;
	localparam int MAX_RAM_BANKS  = 16;
	localparam int RAM_BANK_BYTES = 8192;

	// Controller kinds.
	localparam logic [2:0] KIND_T1 = 3'd1;
	localparam logic [2:0] KIND_T3 = 3'd3;
	localparam logic [2:0] KIND_T5 = 3'd5;

	// Request operations.
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// Configuration register indexes.
	localparam logic [1:0] REG_KIND      = 2'd0;
	localparam logic [1:0] REG_ROM_COUNT = 2'd1;
	localparam logic [1:0] REG_RAM_COUNT = 2'd2;

	// Controller register regions below 0x8000, selected by address bits 14:13.
	localparam logic [1:0] REGION_ENABLE = 2'd0;
	localparam logic [1:0] REGION_ROM    = 2'd1;
	localparam logic [1:0] REGION_UPPER  = 2'd2;
	localparam logic [1:0] REGION_MODE   = 2'd3;

	// External RAM window 0xA000-0xBFFF, matched on address bits 15:13.
	localparam logic [2:0] EXT_RAM_PAGE = 3'b101;

	// Byte that enables external RAM.
	localparam logic [7:0] RAM_ENABLE_KEY = 8'h0A;

	// Result status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_ADDR = 2'd1;
	localparam logic [1:0] ST_RANGE    = 2'd2;
	localparam logic [1:0] ST_NO_CTRL  = 2'd3;

endpackage

[hw/rtl/cartridge_bank_controller_unit.sv]
// Cartridge bank controller for type 1, type 3 and type 5 style cartridges. Each request is
// either a read of external RAM (0xA000-0xBFFF) or a write to a controller register below
// 0x8000, and each request yields exactly one result that carries the selected ROM bank, RAM
// bank and RAM enable after the request, the physical RAM byte offset of a read (bank times
// 8192 plus the offset in the window), an open-bus flag, and a status: ok, invalid address,
// bank out of range, or no controller. A request is registered on acceptance, then decoded
// and applied to the bank state as its result is registered; one request is taken every
// clock while the result register is not stalled, and the single state update between the
// input and result registers sets that rate. A request waits in the input register while
// the result register is stalled. A bank at or above the configured bank count (capped at
// 512 ROM banks and 16 RAM banks) is not taken and is flagged. Controller kind and bank
// counts are written over APB at byte addresses 0, 4 and 8; the user must write them only
// while no request is in flight, which the block does not enforce. pready is always high.
module cartridge_bank_controller_unit
	import cbc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Request channel.
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [15:0] address,
	input  logic [7:0]  value,
	// Result channel.
	output logic        out_valid,
	input  logic        out_stall,
	output logic [8:0]  rom_bank,
	output logic [3:0]  ram_bank,
	output logic        ram_enabled,
	output logic [16:0] ram_offset,
	output logic        open_bus,
	output logic [1:0]  status
);

	// Configuration registers.
	logic [2:0] kind_q;
	logic [9:0] rom_count_q;
	logic [4:0] ram_count_q;

	// Bank state.
	logic [8:0] rom_q;
	logic [3:0] ram_q;
	logic       en_q;
	logic       mode_q;

	// Input register.
	logic        valid_s1;
	logic        op_s1;
	logic [15:0] addr_s1;
	logic [7:0]  val_s1;

	// Result register.
	logic        out_valid_q;
	logic [8:0]  rom_out_q;
	logic [3:0]  ram_out_q;
	logic        en_out_q;
	logic [16:0] off_out_q;
	logic        open_out_q;
	logic [1:0]  status_out_q;

	logic advance;
	logic cfg_write;
	logic kind_ok;

	logic [9:0] rom_lim;
	logic [4:0] ram_lim;

	logic       rom_req;
	logic [8:0] rom_cand;
	logic       ram_req;
	logic [7:0] ram_cand;
	logic [4:0] low_bits;
	logic [6:0] rom7;

	logic [8:0]  nxt_rom;
	logic [3:0]  nxt_ram;
	logic        nxt_en;
	logic        nxt_mode;
	logic [16:0] res_off;
	logic        res_open;
	logic [1:0]  res_status;

	// The result register moves on when it is empty or being taken; the input register
	// holds its request only while the result register is blocked.
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			REG_KIND:      prdata = {29'd0, kind_q};
			REG_ROM_COUNT: prdata = {22'd0, rom_count_q};
			REG_RAM_COUNT: prdata = {27'd0, ram_count_q};
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q      <= 3'd0;
			rom_count_q <= 10'd2;
			ram_count_q <= 5'd1;
		end else if (cfg_write) begin
			unique case (paddr[3:2])
				REG_KIND:      kind_q      <= pwdata[2:0];
				REG_ROM_COUNT: rom_count_q <= pwdata[9:0];
				REG_RAM_COUNT: ram_count_q <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	// Kinds other than the three supported codes behave as no controller.
	assign kind_ok = (kind_q == KIND_T1) || (kind_q == KIND_T3) || (kind_q == KIND_T5);

	// Effective bank limits: counts beyond what the controller can address are capped.
	assign rom_lim = (rom_count_q > 10'(MAX_ROM_BANKS)) ? 10'(MAX_ROM_BANKS) : rom_count_q;
	assign ram_lim = (ram_count_q > 5'(MAX_RAM_BANKS)) ? 5'(MAX_RAM_BANKS) : ram_count_q;

	// Bank number zero is not selectable in the low bank registers and maps to one.
	assign low_bits = (val_s1[4:0] == 5'd0) ? 5'd1 : val_s1[4:0];
	assign rom7     = (val_s1[6:0] == 7'd0) ? 7'd1 : val_s1[6:0];

	always_comb begin
		rom_req    = 1'b0;
		rom_cand   = '0;
		ram_req    = 1'b0;
		ram_cand   = '0;
		nxt_rom    = rom_q;
		nxt_ram    = ram_q;
		nxt_en     = en_q;
		nxt_mode   = mode_q;
		res_off    = '0;
		res_open   = 1'b0;
		res_status = ST_OK;

		if (op_s1 == OP_WRITE) begin
			if (!kind_ok) begin
				res_status = ST_NO_CTRL;
			end else if (addr_s1[15]) begin
				res_status = ST_BAD_ADDR;
			end else begin
				unique case (addr_s1[14:13])
					REGION_ENABLE: begin
						nxt_en = (val_s1 == RAM_ENABLE_KEY);
					end
					REGION_ROM: begin
						rom_req = 1'b1;
						if (kind_q == KIND_T1) begin
							// The two upper bank bits are kept.
							rom_cand = {2'b00, rom_q[6:5], low_bits};
						end else if (kind_q == KIND_T3) begin
							rom_cand = {2'b00, rom7};
						end else if (!addr_s1[12]) begin
							rom_cand = {rom_q[8], val_s1};
						end else begin
							rom_cand = {val_s1[0], rom_q[7:0]};
						end
					end
					REGION_UPPER: begin
						if (kind_q == KIND_T1) begin
							// In RAM mode the two bits pick the RAM bank, otherwise they
							// join the five low ROM bank bits.
							if (mode_q) begin
								ram_req  = 1'b1;
								ram_cand = {6'd0, val_s1[1:0]};
							end else begin
								rom_req  = 1'b1;
								rom_cand = {2'b00, val_s1[1:0], rom_q[4:0]};
							end
						end else begin
							// The whole byte is checked against the RAM bank count.
							ram_req  = 1'b1;
							ram_cand = val_s1;
						end
					end
					REGION_MODE: begin
						if (kind_q == KIND_T1) begin
							nxt_mode = val_s1[0];
							if (val_s1[0]) begin
								rom_req  = 1'b1;
								rom_cand = {4'd0, rom_q[4:0]};
							end else begin
								ram_req  = 1'b1;
								ram_cand = 8'd0;
							end
						end else if (kind_q == KIND_T5) begin
							res_status = ST_BAD_ADDR;
						end
						// A type 3 write to this region changes no state.
					end
					default: ;
				endcase
			end

			if (rom_req) begin
				if ({1'b0, rom_cand} >= rom_lim) begin
					res_status = ST_RANGE;
				end else begin
					nxt_rom = rom_cand;
				end
			end
			if (ram_req) begin
				if (ram_cand >= {3'd0, ram_lim}) begin
					res_status = ST_RANGE;
				end else begin
					nxt_ram = ram_cand[3:0];
				end
			end
		end else begin
			if (addr_s1[15:13] != EXT_RAM_PAGE) begin
				res_open   = 1'b1;
				res_status = ST_BAD_ADDR;
			end else if (!en_q) begin
				res_open = 1'b1;
			end else begin
				res_off = {ram_q, addr_s1[12:0]};
			end
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1   <= operation;
			addr_s1 <= address;
			val_s1  <= value;
		end
	end

	// Bank state is updated together with the result register load.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_q       <= 9'd1;
			ram_q       <= 4'd0;
			en_q        <= 1'b0;
			mode_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				rom_q  <= nxt_rom;
				ram_q  <= nxt_ram;
				en_q   <= nxt_en;
				mode_q <= nxt_mode;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			rom_out_q    <= nxt_rom;
			ram_out_q    <= nxt_ram;
			en_out_q     <= nxt_en;
			off_out_q    <= res_off;
			open_out_q   <= res_open;
			status_out_q <= res_status;
		end
	end

	assign out_valid   = out_valid_q;
	assign rom_bank    = rom_out_q;
	assign ram_bank    = ram_out_q;
	assign ram_enabled = en_out_q;
	assign ram_offset  = off_out_q;
	assign open_bus    = open_out_q;
	assign status      = status_out_q;

endmodule

[hw/rtl/cbc_checker.sv]
`include "assert_macros.svh"

module cbc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [8:0]  rom_bank,
	input logic [3:0]  ram_bank,
	input logic        ram_enabled,
	input logic [16:0] ram_offset,
	input logic        open_bus,
	input logic [1:0]  status
);

	logic [33:0] result_word;
	logic        served_read;

	assign result_word = {rom_bank, ram_bank, ram_enabled, ram_offset, open_bus, status};
	assign served_read = ram_enabled && !open_bus && (ram_offset[16:13] == ram_bank);

	// A stalled result holds its payload.
	`ASSERT_NEXT(a_result_held, clk, arst_n, out_valid && out_stall, out_valid && $stable(result_word))

	// Requests are only held back when a finished result is waiting to be taken.
	`ASSERT_SAME(a_stall_from_output, clk, arst_n, in_valid && in_stall, out_valid && out_stall)

	// A nonzero RAM offset only comes from a read served while RAM is enabled.
	`ASSERT_SAME(a_offset_served, clk, arst_n, out_valid && (ram_offset != 17'd0), served_read)

endmodule

bind cartridge_bank_controller_unit cbc_checker u_cbc_checker (.*);

[dv/cartridge_bank_controller_unit_test.sv]
// Self-checking bench for the cartridge bank controller.
//
// Flow:
//   1. A short directed plan is walked first. It covers reset behavior, every
//      controller kind, bank-zero remap, out-of-range banks and the bank-count caps.
//   2. Random phases follow. Each phase picks a new controller setting and an idling mix.
//
// A local predictor tracks the bank state and the configuration. Each accepted
// request queues one expected result, and the result channel is compared field by
// field against the oldest entry.
module cartridge_bank_controller_unit_test;
	import cbc_pkg::*;

	// Kind code that selects no controller. The other unused codes behave the same.
	localparam logic [2:0] KIND_NONE = 3'd0;
	// Cycles without any handshake before the run is declared hung.
	localparam int QUIET_LIMIT = 2000;
	// Random phases and requests per phase.
	localparam int PHASES = 10;
	localparam int PHASE_REQUESTS = 60;

	typedef struct packed {
		logic [8:0]  rom_bank;
		logic [3:0]  ram_bank;
		logic        ram_enabled;
		logic [16:0] ram_offset;
		logic        open_bus;
		logic [1:0]  status;
	} bank_result_t;

	// One row of the directed plan. A row either reprograms the controller or
	// issues a request. A request row may carry a typed-in expected result.
	typedef struct {
		logic         is_cfg;
		logic [2:0]   kind;
		logic [9:0]   rom_count;
		logic [4:0]   ram_count;
		logic         op;
		logic [15:0]  addr;
		logic [7:0]   val;
		logic         typed;
		bank_result_t want;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        operation = 1'b0;
	logic [15:0] address = '0;
	logic [7:0]  value = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [8:0]  rom_bank;
	logic [3:0]  ram_bank;
	logic        ram_enabled;
	logic [16:0] ram_offset;
	logic        open_bus;
	logic [1:0]  status;

	cartridge_bank_controller_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.address    (address),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.rom_bank   (rom_bank),
		.ram_bank   (ram_bank),
		.ram_enabled(ram_enabled),
		.ram_offset (ram_offset),
		.open_bus   (open_bus),
		.status     (status)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Predictor copy of the configuration and of the bank state.
	logic [2:0] pred_kind = KIND_NONE;
	logic [9:0] pred_rom_count = 10'd2;
	logic [4:0] pred_ram_count = 5'd1;
	logic [8:0] pred_rom = 9'd1;
	logic [3:0] pred_ram = '0;
	logic       pred_en = 1'b0;
	logic       pred_mode = 1'b0;

	bank_result_t pending_results[$];
	plan_row_t    directed_plan[$];

	int idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;
	int failures = 0;
	int requests_sent = 0;
	int results_seen = 0;
	int settings_used = 0;

	// A ROM bank selection is taken only below the capped bank count.
	function automatic logic [1:0] take_rom(int bank);
		int lim;
		lim = (pred_rom_count > MAX_ROM_BANKS) ? MAX_ROM_BANKS : int'(pred_rom_count);
		if (bank >= lim) return ST_RANGE;
		pred_rom = bank[8:0];
		return ST_OK;
	endfunction

	function automatic logic [1:0] take_ram(int bank);
		int lim;
		lim = (pred_ram_count > MAX_RAM_BANKS) ? MAX_RAM_BANKS : int'(pred_ram_count);
		if (bank >= lim) return ST_RANGE;
		pred_ram = bank[3:0];
		return ST_OK;
	endfunction

	// Applies one request to the predicted state and returns the result it should give.
	function automatic bank_result_t predict_access(logic op, logic [15:0] a, logic [7:0] v);
		bank_result_t r;
		logic [1:0] st;
		int vi;
		int ri;
		int low;
		int off;
		r = '0;
		st = ST_OK;
		vi = int'(v);
		ri = int'(pred_rom);
		if (op == OP_WRITE) begin
			if (pred_kind != KIND_T1 && pred_kind != KIND_T3 && pred_kind != KIND_T5) begin
				st = ST_NO_CTRL;
			end else if (a[15]) begin
				st = ST_BAD_ADDR;
			end else begin
				case (a[14:13])
					REGION_ENABLE: begin
						pred_en = (v == RAM_ENABLE_KEY);
					end
					REGION_ROM: begin
						if (pred_kind == KIND_T1) begin
							low = vi & 'h1F;
							if (low == 0) low = 1;
							st = take_rom((ri & 'h60) | low);
						end else if (pred_kind == KIND_T3) begin
							low = vi & 'h7F;
							if (low == 0) low = 1;
							st = take_rom(low);
						end else if (!a[12]) begin
							st = take_rom((ri & 'h100) | vi);
						end else begin
							st = take_rom((ri & 'hFF) | ((vi & 1) << 8));
						end
					end
					REGION_UPPER: begin
						if (pred_kind != KIND_T1) st = take_ram(vi);
						else if (pred_mode) st = take_ram(vi & 3);
						else st = take_rom(((vi & 3) << 5) | (ri & 'h1F));
					end
					default: begin
						if (pred_kind == KIND_T1) begin
							pred_mode = v[0];
							if (pred_mode) st = take_rom(ri & 'h1F);
							else st = take_ram(0);
						end else if (pred_kind == KIND_T5) begin
							st = ST_BAD_ADDR;
						end
						// A type 3 write to this region changes no state.
					end
				endcase
			end
		end else begin
			off = (int'(a) - 'hA000) & 'hFFFF;
			if (off > 'h1FFF) begin
				r.open_bus = 1'b1;
				st = ST_BAD_ADDR;
			end else if (!pred_en) begin
				r.open_bus = 1'b1;
			end else begin
				r.ram_offset = 17'(int'(pred_ram) * RAM_BANK_BYTES + off);
			end
		end
		r.rom_bank = pred_rom;
		r.ram_bank = pred_ram;
		r.ram_enabled = pred_en;
		r.status = st;
		return r;
	endfunction

	function automatic bank_result_t typed_result(int rb, int mb, int en, int off, int ob,
			logic [1:0] st);
		bank_result_t r;
		r.rom_bank = 9'(rb);
		r.ram_bank = 4'(mb);
		r.ram_enabled = en[0];
		r.ram_offset = 17'(off);
		r.open_bus = ob[0];
		r.status = st;
		return r;
	endfunction

	function automatic void plan_cfg(logic [2:0] k, int rc, int mc);
		plan_row_t row;
		row = '{default: '0};
		row.is_cfg = 1'b1;
		row.kind = k;
		row.rom_count = 10'(rc);
		row.ram_count = 5'(mc);
		directed_plan.push_back(row);
	endfunction

	function automatic void plan_req(logic op, logic [15:0] a, logic [7:0] v, logic typed,
			bank_result_t want);
		plan_row_t row;
		row = '{default: '0};
		row.op = op;
		row.addr = a;
		row.val = v;
		row.typed = typed;
		row.want = want;
		directed_plan.push_back(row);
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endtask

	// The result checker samples the channel at each rising edge. It then draws the next
	// stall, so a stall decision always applies to the following edge.
	always @(posedge clk) begin : result_check
		bank_result_t want;
		logic in_fire;
		logic out_fire;
		in_fire = in_valid && !in_stall;
		out_fire = arst_n && out_valid && !out_stall;
		if (out_fire) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("result arrived with no request waiting for it");
				failures++;
			end else begin
				want = pending_results.pop_front();
				check_field("rom_bank", 32'(want.rom_bank), 32'(rom_bank));
				check_field("ram_bank", 32'(want.ram_bank), 32'(ram_bank));
				check_field("ram_enabled", 32'(want.ram_enabled), 32'(ram_enabled));
				check_field("ram_offset", 32'(want.ram_offset), 32'(ram_offset));
				check_field("open_bus", 32'(want.open_bus), 32'(open_bus));
				check_field("status", 32'(want.status), 32'(status));
			end
		end
		if (in_fire || out_fire) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// The watchdog ends a hung run. It counts cycles in which no request and no result moved.
	initial begin : watchdog
		do @(posedge clk); while (quiet_cycles < QUIET_LIMIT);
		$display("cartridge_bank_controller_unit_test: FAIL");
		$finish;
	end

	// Holds the request channel idle until every result is back.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One register write over APB. It is followed by a read-back of the masked value.
	// psel stays high from the write access into the read setup.
	task automatic write_reg(logic [1:0] idx, logic [31:0] data, logic [31:0] keep);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== (data & keep)) begin
			$error("register %0d: expected %0h, got %0h", idx, data & keep, prdata);
			failures++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Programs all three registers. Random upper bits of the write data check that
	// only the defined bits are kept.
	task automatic write_config(logic [2:0] k, logic [9:0] rc, logic [4:0] mc);
		logic [31:0] word;
		word = $urandom();
		word[2:0] = k;
		write_reg(REG_KIND, word, 32'h7);
		word = $urandom();
		word[9:0] = rc;
		write_reg(REG_ROM_COUNT, word, 32'h3FF);
		word = $urandom();
		word[4:0] = mc;
		write_reg(REG_RAM_COUNT, word, 32'h1F);
		pred_kind = k;
		pred_rom_count = rc;
		pred_ram_count = mc;
		settings_used++;
	endtask

	// Presents one request, after a random idle gap, and waits for it to be taken.
	// The expected result is queued at the edge that accepts the request.
	task automatic push_request(logic op, logic [15:0] a, logic [7:0] v, logic typed,
			bank_result_t want);
		bank_result_t guess;
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < idle_pct) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		address <= a;
		value <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		guess = predict_access(op, a, v);
		pending_results.push_back(typed ? want : guess);
		requests_sent++;
	endtask

	// Most random requests are well-formed register writes and window reads. Their
	// contents are random. About a tenth are noise: any operation, address and byte.
	task automatic random_request(output logic op, output logic [15:0] a, output logic [7:0] v);
		int pick;
		pick = $urandom_range(0, 99);
		op = OP_WRITE;
		v = 8'($urandom_range(0, 255));
		if (pick < 12) begin
			a = {1'b0, REGION_ENABLE, 13'($urandom_range(0, 'h1FFF))};
			if ($urandom_range(0, 2) != 0) v = RAM_ENABLE_KEY;
		end else if (pick < 40) begin
			a = {1'b0, REGION_ROM, 13'($urandom_range(0, 'h1FFF))};
		end else if (pick < 55) begin
			a = {1'b0, REGION_UPPER, 13'($urandom_range(0, 'h1FFF))};
			if ($urandom_range(0, 2) != 0) v = 8'($urandom_range(0, 15));
		end else if (pick < 63) begin
			a = {1'b0, REGION_MODE, 13'($urandom_range(0, 'h1FFF))};
		end else if (pick < 90) begin
			op = OP_READ;
			a = {EXT_RAM_PAGE, 13'($urandom_range(0, 'h1FFF))};
		end else begin
			op = 1'($urandom_range(0, 1));
			a = 16'($urandom_range(0, 'hFFFF));
		end
	endtask

	initial begin : stimulus
		plan_row_t row;
		logic op;
		logic [15:0] a;
		logic [7:0] v;
		logic [2:0] k;
		logic [9:0] rc;
		logic [4:0] mc;

		// Out of reset the kind is none. Writes are refused, while reads still decode
		// the window with RAM disabled.
		plan_req(OP_WRITE, 16'h0000, RAM_ENABLE_KEY, 1'b1, typed_result(1, 0, 0, 0, 0, ST_NO_CTRL));
		plan_req(OP_READ, 16'hA000, 8'h00, 1'b1, typed_result(1, 0, 0, 0, 1, ST_OK));
		plan_req(OP_READ, 16'h0000, 8'hFF, 1'b1, typed_result(1, 0, 0, 0, 1, ST_BAD_ADDR));
		plan_req(OP_WRITE, 16'hFFFF, 8'hFF, 1'b1, typed_result(1, 0, 0, 0, 0, ST_NO_CTRL));
		// Type 1 walk: bank-zero remap, upper bits in ROM mode, mode switch masking,
		// and the RAM bank in RAM mode.
		plan_cfg(KIND_T1, MAX_ROM_BANKS, MAX_RAM_BANKS);
		plan_req(OP_WRITE, 16'h0000, RAM_ENABLE_KEY, 1'b0, '0);
		plan_req(OP_WRITE, 16'h2000, 8'h00, 1'b0, '0);
		plan_req(OP_WRITE, 16'h3FFF, 8'h1F, 1'b0, '0);
		plan_req(OP_WRITE, 16'h4000, 8'h03, 1'b0, '0);
		plan_req(OP_WRITE, 16'h6000, 8'h01, 1'b0, '0);
		plan_req(OP_WRITE, 16'h5FFF, 8'hFF, 1'b0, '0);
		plan_req(OP_READ, 16'hBFFF, 8'h00, 1'b0, '0);
		plan_req(OP_WRITE, 16'h7FFF, 8'h00, 1'b0, '0);
		plan_req(OP_WRITE, 16'h8000, 8'h00, 1'b0, '0);
		plan_req(OP_READ, 16'h9FFF, 8'h00, 1'b0, '0);
		// Type 3 with a single ROM bank and no RAM banks. Every selection is rejected,
		// and the clock latch write does nothing.
		plan_cfg(KIND_T3, 1, 0);
		plan_req(OP_WRITE, 16'h2000, 8'h7F, 1'b0, '0);
		plan_req(OP_WRITE, 16'h4000, 8'h00, 1'b0, '0);
		plan_req(OP_WRITE, 16'h6000, 8'h00, 1'b0, '0);
		plan_req(OP_WRITE, 16'h1000, 8'h0B, 1'b0, '0);
		plan_req(OP_READ, 16'hA000, 8'h00, 1'b0, '0);
		// Type 5 with counts above the caps. This walk selects ROM bank 0x1FF and RAM
		// bank 15, then reads the last byte of RAM.
		plan_cfg(KIND_T5, 1023, 31);
		plan_req(OP_WRITE, 16'h0000, RAM_ENABLE_KEY, 1'b0, '0);
		plan_req(OP_WRITE, 16'h2000, 8'hFF, 1'b0, '0);
		plan_req(OP_WRITE, 16'h3000, 8'h01, 1'b0, '0);
		plan_req(OP_WRITE, 16'h4000, 8'h10, 1'b0, '0);
		plan_req(OP_WRITE, 16'h4000, 8'h0F, 1'b0, '0);
		plan_req(OP_READ, 16'hBFFF, 8'h00, 1'b1, typed_result('h1FF, 15, 1, 131071, 0, ST_OK));
		plan_req(OP_WRITE, 16'h6000, 8'h00, 1'b1, typed_result('h1FF, 15, 1, 0, 0, ST_BAD_ADDR));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[i]) begin
			row = directed_plan[i];
			if (row.is_cfg) begin
				wait_idle();
				write_config(row.kind, row.rom_count, row.ram_count);
			end else begin
				push_request(row.op, row.addr, row.val, row.typed, row.want);
			end
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase % 5)
				0: k = KIND_T1;
				1: k = KIND_T3;
				2: k = KIND_T5;
				3: k = ($urandom_range(0, 1) != 0) ? KIND_T1 : KIND_T5;
				default: begin
					do k = 3'($urandom_range(0, 7));
					while (k == KIND_T1 || k == KIND_T3 || k == KIND_T5);
				end
			endcase
			case ($urandom_range(0, 5))
				0: rc = 10'd0;
				1: rc = 10'd1;
				2: rc = 10'(MAX_ROM_BANKS);
				3: rc = 10'h3FF;
				default: rc = 10'($urandom_range(64, 600));
			endcase
			case ($urandom_range(0, 5))
				0: mc = 5'd0;
				1: mc = 5'd1;
				2: mc = 5'(MAX_RAM_BANKS);
				3: mc = 5'h1F;
				default: mc = 5'($urandom_range(1, 16));
			endcase
			wait_idle();
			write_config(k, rc, mc);
			case (phase % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 56; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 56; end
				default: begin idle_pct = 22; stall_pct = 22; end
			endcase
			for (int n = 0; n < PHASE_REQUESTS; n++) begin
				// Once in the run, the sender holds off until the block has drained.
				if (phase == 5 && n == PHASE_REQUESTS / 2) wait_idle();
				random_request(op, a, v);
				push_request(op, a, v, 1'b0, '0);
			end
		end

		wait_idle();
		repeat (8) @(posedge clk);
		$display("Ran %0d requests and checked %0d results under %0d controller settings,",
			requests_sent, results_seen, settings_used);
		$display("covering every kind, bank-count extremes and four idle/stall mixes.");
		if (failures == 0) begin
			$display("cartridge_bank_controller_unit_test: PASS");
		end else begin
			$display("cartridge_bank_controller_unit_test: FAIL");
		end
		$finish;
	end

endmodule
